### hdl/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg
// widths shared by the segment / circle crossing test
// ----------------------------------------------------------------------------
package sci_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned RAD_W   = 15;
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned PROD_W  = 2 * DIFF_W;
    localparam int unsigned RSQ_W   = 2 * RAD_W;
    localparam int unsigned SUM_W   = PROD_W + 1;
    localparam int unsigned AH_W    = SUM_W + 1;
    localparam int unsigned G1_W    = SUM_W + 2;
    localparam int unsigned MAG_W   = PROD_W;
    localparam int unsigned WIDE_W  = 2 * MAG_W;
    localparam int unsigned NSTAGE  = 5;

endpackage

### hdl/sci_if.sv
// ----------------------------------------------------------------------------
// sci_if
// valid / ready channels for segment beats and hit beats
// ----------------------------------------------------------------------------
interface sci_seg_if;
    logic                              valid;
    logic                              ready;
    logic signed [sci_pkg::COORD_W-1:0] from_x;
    logic signed [sci_pkg::COORD_W-1:0] from_y;
    logic signed [sci_pkg::COORD_W-1:0] to_x;
    logic signed [sci_pkg::COORD_W-1:0] to_y;
    logic signed [sci_pkg::COORD_W-1:0] center_x;
    logic signed [sci_pkg::COORD_W-1:0] center_y;
    logic        [sci_pkg::RAD_W-1:0]   radius;

    modport source (
        output valid, from_x, from_y, to_x, to_y, center_x, center_y, radius,
        input  ready
    );
    modport sink (
        input  valid, from_x, from_y, to_x, to_y, center_x, center_y, radius,
        output ready
    );
endinterface

interface sci_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );
    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

### hdl/sci_disc.sv
// ----------------------------------------------------------------------------
// sci_disc
// discriminant stage: registers h^2 and a*c, compares h^2 >= a*c
// ----------------------------------------------------------------------------
module sci_disc (
    input  logic                        clk,
    input  logic                        load,
    input  logic [sci_pkg::MAG_W-1:0]   habs,
    input  logic [sci_pkg::MAG_W-1:0]   a,
    input  logic [sci_pkg::MAG_W-1:0]   cmag,
    output logic                        ge
);

    logic [sci_pkg::WIDE_W-1:0] hsq_reg;
    logic [sci_pkg::WIDE_W-1:0] hsq_next;
    logic [sci_pkg::WIDE_W-1:0] ac_reg;
    logic [sci_pkg::WIDE_W-1:0] ac_next;

    assign hsq_next = habs * habs;
    assign ac_next  = a * cmag;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hsq_reg <= hsq_next;
            ac_reg  <= ac_next;
        end
    end

    assign ge = (hsq_reg >= ac_reg);

endmodule

### hdl/segment_circle_intersect.sv
// ----------------------------------------------------------------------------
// segment_circle_intersect
// Tests one segment against one circle per beat and reports whether the
// segment crosses the circle at a parameter t in [0,1]. Coordinates are
// signed Q8.8, radius unsigned Q7.8; the test is exact integer arithmetic
// (no square root, no division). A zero-length segment, a negative
// discriminant and a segment lying wholly inside the circle report no hit.
// A new beat is taken every cycle while the output is not stalled. Each
// beat enters the first of five compute stages at the accepting edge, and
// the output register follows the last. The depth is set by the chain of
// 17x17 products, their sums, and the 34x34 products of the discriminant
// test. Stages with no valid beat close up under a stall.
// ----------------------------------------------------------------------------
module segment_circle_intersect (
    input  logic             clk,
    input  logic             rst_n,
    sci_seg_if.sink          seg_in,
    sci_hit_if.source        hit_out
);

    localparam int unsigned NS = sci_pkg::NSTAGE;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   load;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          hit_reg;
    logic          hit_next;

    // stage 0: differences
    logic signed [sci_pkg::DIFF_W-1:0] dx_reg, dy_reg, gx_reg, gy_reg;
    logic signed [sci_pkg::DIFF_W-1:0] dx_next, dy_next, gx_next, gy_next;
    logic        [sci_pkg::RAD_W-1:0]  r_reg;

    // stage 1: products
    logic signed [sci_pkg::PROD_W-1:0] pdx_reg, pdy_reg, pgd_x_reg, pgd_y_reg;
    logic signed [sci_pkg::PROD_W-1:0] pgx_reg, pgy_reg;
    logic signed [sci_pkg::PROD_W-1:0] pdx_next, pdy_next, pgd_x_next, pgd_y_next;
    logic signed [sci_pkg::PROD_W-1:0] pgx_next, pgy_next;
    logic        [sci_pkg::RSQ_W-1:0]  rsq_reg;
    logic        [sci_pkg::RSQ_W-1:0]  rsq_next;

    // stage 2: quadratic coefficients
    logic signed [sci_pkg::SUM_W-1:0] a_reg, h_reg, c_reg;
    logic signed [sci_pkg::SUM_W-1:0] a_next, h_next, c_next;

    // stage 3: root window flags
    logic signed [sci_pkg::AH_W-1:0]  ah;
    logic signed [sci_pkg::G1_W-1:0]  g1;
    logic signed [sci_pkg::SUM_W-1:0] hneg;
    logic [sci_pkg::MAG_W-1:0]        habs_reg, amag_reg, cmag_reg;
    logic [sci_pkg::MAG_W-1:0]        habs_next;
    logic                             azero_reg, cpos_reg, troot_reg;
    logic                             azero_next, cpos_next, troot_next;
    logic                             h_le0, c_ge0, c_le0, ah_ge0, g1_le0, g1_ge0;

    // stage 4: discriminant products
    logic                             azero4_reg, cpos4_reg, troot4_reg;
    logic                             disc_ge;

    // load chain: a stage takes new data when empty or when it drains
    always_comb
    begin
        load[NS] = !out_valid_reg || hit_out.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign seg_in.ready = load[0];

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = seg_in.valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (load[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
        out_valid_next = load[NS] ? valid_reg[NS-1] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage 0
    assign dx_next = {seg_in.to_x[sci_pkg::COORD_W-1], seg_in.to_x}
                   - {seg_in.from_x[sci_pkg::COORD_W-1], seg_in.from_x};
    assign dy_next = {seg_in.to_y[sci_pkg::COORD_W-1], seg_in.to_y}
                   - {seg_in.from_y[sci_pkg::COORD_W-1], seg_in.from_y};
    assign gx_next = {seg_in.from_x[sci_pkg::COORD_W-1], seg_in.from_x}
                   - {seg_in.center_x[sci_pkg::COORD_W-1], seg_in.center_x};
    assign gy_next = {seg_in.from_y[sci_pkg::COORD_W-1], seg_in.from_y}
                   - {seg_in.center_y[sci_pkg::COORD_W-1], seg_in.center_y};

    // stage 1
    assign pdx_next   = dx_reg * dx_reg;
    assign pdy_next   = dy_reg * dy_reg;
    assign pgd_x_next = gx_reg * dx_reg;
    assign pgd_y_next = gy_reg * dy_reg;
    assign pgx_next   = gx_reg * gx_reg;
    assign pgy_next   = gy_reg * gy_reg;
    assign rsq_next   = r_reg * r_reg;

    // stage 2
    assign a_next = sci_pkg::SUM_W'(pdx_reg) + sci_pkg::SUM_W'(pdy_reg);
    assign h_next = sci_pkg::SUM_W'(pgd_x_reg) + sci_pkg::SUM_W'(pgd_y_reg);
    assign c_next = sci_pkg::SUM_W'(pgx_reg) + sci_pkg::SUM_W'(pgy_reg)
                  - sci_pkg::SUM_W'(rsq_reg);

    // stage 3
    assign ah     = sci_pkg::AH_W'(a_reg) + sci_pkg::AH_W'(h_reg);
    assign g1     = sci_pkg::G1_W'(a_reg) + sci_pkg::G1_W'(h_reg)
                  + sci_pkg::G1_W'(h_reg) + sci_pkg::G1_W'(c_reg);
    assign hneg   = -h_reg;
    assign h_le0  = h_reg[sci_pkg::SUM_W-1] || (h_reg == '0);
    assign c_ge0  = !c_reg[sci_pkg::SUM_W-1];
    assign c_le0  = c_reg[sci_pkg::SUM_W-1] || (c_reg == '0);
    assign ah_ge0 = !ah[sci_pkg::AH_W-1];
    assign g1_ge0 = !g1[sci_pkg::G1_W-1];
    assign g1_le0 = g1[sci_pkg::G1_W-1] || (g1 == '0);

    assign habs_next  = h_reg[sci_pkg::SUM_W-1] ? hneg[sci_pkg::MAG_W-1:0]
                                                : h_reg[sci_pkg::MAG_W-1:0];
    assign azero_next = (a_reg == '0);
    assign cpos_next  = !c_le0;
    // smaller root in window, or larger root in window
    assign troot_next = (h_le0 && c_ge0 && (ah_ge0 || g1_le0))
                     || ((h_le0 || c_le0) && ah_ge0 && g1_ge0);

    // stage 4
    sci_disc u_disc (
        .clk  (clk),
        .load (load[4]),
        .habs (habs_reg),
        .a    (amag_reg),
        .cmag (cmag_reg),
        .ge   (disc_ge)
    );

    // output
    assign hit_next = !azero4_reg && troot4_reg && (!cpos4_reg || disc_ge);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            r_reg  <= seg_in.radius;
        end
        if (load[1])
        begin
            pdx_reg   <= pdx_next;
            pdy_reg   <= pdy_next;
            pgd_x_reg <= pgd_x_next;
            pgd_y_reg <= pgd_y_next;
            pgx_reg   <= pgx_next;
            pgy_reg   <= pgy_next;
            rsq_reg   <= rsq_next;
        end
        if (load[2])
        begin
            a_reg <= a_next;
            h_reg <= h_next;
            c_reg <= c_next;
        end
        if (load[3])
        begin
            habs_reg  <= habs_next;
            amag_reg  <= a_reg[sci_pkg::MAG_W-1:0];
            cmag_reg  <= c_reg[sci_pkg::MAG_W-1:0];
            azero_reg <= azero_next;
            cpos_reg  <= cpos_next;
            troot_reg <= troot_next;
        end
        if (load[4])
        begin
            azero4_reg <= azero_reg;
            cpos4_reg  <= cpos_reg;
            troot4_reg <= troot_reg;
        end
        if (load[NS])
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit_out.valid = out_valid_reg;
    assign hit_out.hit   = hit_reg;

`ifndef SYNTH
    // input only stalls when every stage holds a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !seg_in.ready |-> (&valid_reg) && out_valid_reg && !hit_out.ready)
        else $error("input stalled with a free stage");

    // an accepted beat lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_in.valid && seg_in.ready |=> valid_reg[0])
        else $error("accepted beat lost at stage 0");

    // a delivered result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_out.ready && !valid_reg[NS-1] |=> !out_valid_reg)
        else $error("result repeated");

    // a beat in the last stage is never dropped while it waits
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-1] && !load[NS] |=> valid_reg[NS-1])
        else $error("last stage beat dropped");
`endif

endmodule
